// File: rtl/arbitrary_axis_rotation_matrix_core_macros.svh
// assertion macros used by aarm_checker
`ifndef ARBITRARY_AXIS_ROTATION_MATRIX_CORE_MACROS_SVH
`define ARBITRARY_AXIS_ROTATION_MATRIX_CORE_MACROS_SVH

// same-cycle implication
`define AARM_ASSERT_IMPL(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define AARM_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/aarm_pkg.sv
package aarm_pkg;

	localparam int COORD_W          = 32;
	localparam int OUT_W            = 48;
	localparam int FRAC_BITS_DEF    = 16;
	localparam int CORDIC_STEPS_DEF = 20;
	localparam int Q                = 30;

	localparam logic signed [33:0] ONE_Q30     = 34'sd1073741824;
	localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
	localparam logic signed [25:0] DEG2RAD_Q30 = 26'sd18740330;

	localparam logic [29:0] ATAN_Q30 [32] = '{
		30'd843314856, 30'd497837829, 30'd263043836, 30'd133525158, 30'd67021686,
		30'd33543515, 30'd16775850, 30'd8388437, 30'd4194282, 30'd2097149,
		30'd1048575, 30'd524287, 30'd262143, 30'd131071, 30'd65535, 30'd32767,
		30'd16383, 30'd8191, 30'd4095, 30'd2047, 30'd1023, 30'd511, 30'd255,
		30'd127, 30'd63, 30'd31, 30'd15, 30'd8, 30'd4, 30'd2, 30'd1, 30'd0
	};

	localparam int SQRT_STEPS = 31;
	localparam int DIV_STEPS  = 31;
	// diff, abs, max, lead, shift, square, sum, sqrt, numerator, divide, sign
	localparam int AXIS_LAT   = 7 + SQRT_STEPS + 1 + DIV_STEPS + 1;

	localparam logic [1:0] ROW_FIRST = 2'd0;
	localparam logic [1:0] ROW_MID   = 2'd1;
	localparam logic [1:0] ROW_LAST  = 2'd2;

	typedef struct packed {
		logic             degen;
		logic [2:0]       neg;
		logic [2:0][29:0] mag;
		logic [2:0][31:0] pnt;
	} axis_side_t;

	// divide by 2^sh, rounding half away from zero
	function automatic logic signed [71:0] rnd_shift(input logic signed [71:0] v,
			input int unsigned sh);
		logic [71:0] m;
		logic [71:0] r;
		if (sh == 0)
			return v;
		m = v[71] ? 72'(-v) : 72'(v);
		m = (m + (72'(1) << (sh - 1))) >> sh;
		r = v[71] ? -m : m;
		return signed'(r);
	endfunction

endpackage

// File: rtl/aarm_axis.sv
module aarm_axis (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     en,
	input  logic                     in_valid,
	input  logic signed [31:0]       pa [3],
	input  logic signed [31:0]       pb [3],
	output logic                     valid,
	output logic signed [31:0]       n [3],
	output logic signed [31:0]       a [3],
	output logic                     degen
);

	localparam int SQ = aarm_pkg::SQRT_STEPS;
	localparam int DV = aarm_pkg::DIV_STEPS;

	function automatic logic [5:0] lead33(input logic [32:0] v);
		logic [5:0] p;
		p = '0;
		for (int i = 0; i < 33; i++)
			if (v[i]) p = 6'(i);
		return p;
	endfunction

	logic                    v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic signed [31:0]      a_s1 [3];
	logic signed [32:0]      d_s1 [3];
	logic [32:0]             mag_s2 [3], mag_s3 [3], mag_s4 [3];
	logic [2:0]              neg_s2, neg_s3, neg_s4;
	logic                    dg_s2, dg_s3, dg_s4;
	logic [2:0][31:0]        pnt_s2, pnt_s3, pnt_s4;
	logic [32:0]             mx_s3;
	logic [5:0]              p_s4;
	aarm_pkg::axis_side_t    side_s5, side_s6;
	logic [59:0]             sq_s6 [3];

	logic                    v_sq [SQ+1];
	logic [61:0]             rem_sq [SQ+1];
	logic [61:0]             root_sq [SQ+1];
	aarm_pkg::axis_side_t    side_sq [SQ+1];

	logic                    v_dv [DV+1];
	logic [2:0][61:0]        rem_dv [DV+1];
	logic [2:0][30:0]        q_dv [DV+1];
	logic [30:0]             l_dv [DV+1];
	aarm_pkg::axis_side_t    side_dv [DV+1];

	logic [30:0]             l_root;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_sq[0] <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_sq[0] <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				a_s1[i] <= pa[i];
				d_s1[i] <= 33'(pb[i]) - 33'(pa[i]);
				mag_s2[i] <= d_s1[i][32] ? 33'(-d_s1[i]) : 33'(d_s1[i]);
				neg_s2[i] <= d_s1[i][32];
				pnt_s2[i] <= a_s1[i];
			end
			dg_s2 <= (d_s1[0] == '0) && (d_s1[1] == '0) && (d_s1[2] == '0);

			mag_s3 <= mag_s2;
			neg_s3 <= neg_s2;
			dg_s3  <= dg_s2;
			pnt_s3 <= pnt_s2;
			if (mag_s2[0] >= mag_s2[1] && mag_s2[0] >= mag_s2[2])
				mx_s3 <= mag_s2[0];
			else if (mag_s2[1] >= mag_s2[2])
				mx_s3 <= mag_s2[1];
			else
				mx_s3 <= mag_s2[2];

			mag_s4 <= mag_s3;
			neg_s4 <= neg_s3;
			dg_s4  <= dg_s3;
			pnt_s4 <= pnt_s3;
			p_s4   <= lead33(mx_s3);

			// common shift puts the largest magnitude in [2^29, 2^30)
			for (int i = 0; i < 3; i++) begin
				if (p_s4 >= 6'd29)
					side_s5.mag[i] <= 30'(mag_s4[i] >> (p_s4 - 6'd29));
				else
					side_s5.mag[i] <= 30'(mag_s4[i] << (6'd29 - p_s4));
			end
			side_s5.neg   <= neg_s4;
			side_s5.degen <= dg_s4;
			side_s5.pnt   <= pnt_s4;

			for (int i = 0; i < 3; i++)
				sq_s6[i] <= 60'(side_s5.mag[i]) * 60'(side_s5.mag[i]);
			side_s6 <= side_s5;

			rem_sq[0]  <= 62'(sq_s6[0]) + 62'(sq_s6[1]) + 62'(sq_s6[2]);
			root_sq[0] <= '0;
			side_sq[0] <= side_s6;
		end
	end

	// integer square root, one result bit per stage
	for (genvar k = 0; k < SQ; k++) begin : g_sqrt
		localparam logic [61:0] BIT = 62'(1) << (2 * (SQ - 1 - k));
		logic [61:0] trial;
		assign trial = root_sq[k] + BIT;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				v_sq[k+1] <= 1'b0;
			else if (en)
				v_sq[k+1] <= v_sq[k];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				side_sq[k+1] <= side_sq[k];
				if (rem_sq[k] >= trial) begin
					rem_sq[k+1]  <= rem_sq[k] - trial;
					root_sq[k+1] <= (root_sq[k] >> 1) + BIT;
				end else begin
					rem_sq[k+1]  <= rem_sq[k];
					root_sq[k+1] <= root_sq[k] >> 1;
				end
			end
		end
	end

	assign l_root = root_sq[SQ][30:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_dv[0] <= 1'b0;
		else if (en)
			v_dv[0] <= v_sq[SQ];
	end

	// numerator with half divisor added for round half up
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++)
				rem_dv[0][i] <= 62'({side_sq[SQ].mag[i], 30'b0}) + 62'(l_root >> 1);
			q_dv[0]    <= '0;
			l_dv[0]    <= l_root;
			side_dv[0] <= side_sq[SQ];
		end
	end

	// restoring division, one quotient bit per stage, three lanes
	for (genvar k = 0; k < DV; k++) begin : g_div
		localparam int J = DV - 1 - k;
		logic [61:0] sub;
		assign sub = 62'(l_dv[k]) << J;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				v_dv[k+1] <= 1'b0;
			else if (en)
				v_dv[k+1] <= v_dv[k];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				l_dv[k+1]    <= l_dv[k];
				side_dv[k+1] <= side_dv[k];
				for (int i = 0; i < 3; i++) begin
					if (rem_dv[k][i] >= sub) begin
						rem_dv[k+1][i]  <= rem_dv[k][i] - sub;
						q_dv[k+1][i]    <= q_dv[k][i] | (31'(1) << J);
					end else begin
						rem_dv[k+1][i]  <= rem_dv[k][i];
						q_dv[k+1][i]    <= q_dv[k][i];
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid <= 1'b0;
		else if (en)
			valid <= v_dv[DV];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				n[i] <= side_dv[DV].neg[i] ? -32'(q_dv[DV][i]) : 32'(q_dv[DV][i]);
				a[i] <= side_dv[DV].pnt[i];
			end
			degen <= side_dv[DV].degen;
		end
	end

endmodule

// File: rtl/aarm_angle.sv
module aarm_angle #(
	parameter int FRAC_BITS    = aarm_pkg::FRAC_BITS_DEF,
	parameter int CORDIC_STEPS = aarm_pkg::CORDIC_STEPS_DEF
) (
	input  logic                        clk,
	input  logic                        en,
	input  logic signed [FRAC_BITS+9:0] angle,
	output logic signed [33:0]          c,
	output logic signed [33:0]          s
);

	localparam int AW  = FRAC_BITS + 10;
	localparam int TW  = AW + 1;
	localparam int PW  = TW + 26;
	localparam int PAD = aarm_pkg::AXIS_LAT - 6 - CORDIC_STEPS;

	localparam logic signed [63:0] FULL64 = 64'sd360 <<< FRAC_BITS;
	localparam logic signed [63:0] HALF64 = 64'sd180 <<< FRAC_BITS;
	localparam logic signed [63:0] QRTR64 = 64'sd90 <<< FRAC_BITS;
	localparam logic signed [TW-1:0] FULL = TW'(FULL64);
	localparam logic signed [TW-1:0] HALF = TW'(HALF64);
	localparam logic signed [TW-1:0] QRTR = TW'(QRTR64);

	logic signed [TW-1:0] t_s1, t_s2, t_s3;
	logic                 neg_s3, neg_s4;
	logic signed [PW-1:0] prod_s4;

	logic signed [33:0]   x_c [CORDIC_STEPS+1];
	logic signed [33:0]   y_c [CORDIC_STEPS+1];
	logic signed [32:0]   z_c [CORDIC_STEPS+1];
	logic                 neg_c [CORDIC_STEPS+1];

	logic signed [33:0]   c_pd [PAD+1];
	logic signed [33:0]   s_pd [PAD+1];

	logic signed [TW-1:0] t_in;
	assign t_in = TW'(angle);

	always_ff @(posedge clk) begin
		if (en) begin
			// remainder keeps the sign of the angle
			if (t_in >= FULL)
				t_s1 <= t_in - FULL;
			else if (t_in <= -FULL)
				t_s1 <= t_in + FULL;
			else
				t_s1 <= t_in;

			if (t_s1 > HALF)
				t_s2 <= t_s1 - FULL;
			else if (t_s1 <= -HALF)
				t_s2 <= t_s1 + FULL;
			else
				t_s2 <= t_s1;

			// fold into [-90, 90], negate c and s at the end
			if (t_s2 > QRTR) begin
				t_s3   <= t_s2 - HALF;
				neg_s3 <= 1'b1;
			end else if (t_s2 < -QRTR) begin
				t_s3   <= t_s2 + HALF;
				neg_s3 <= 1'b1;
			end else begin
				t_s3   <= t_s2;
				neg_s3 <= 1'b0;
			end

			prod_s4 <= PW'(t_s3) * PW'(aarm_pkg::DEG2RAD_Q30);
			neg_s4  <= neg_s3;

			z_c[0]   <= 33'(aarm_pkg::rnd_shift(72'(prod_s4), FRAC_BITS));
			x_c[0]   <= aarm_pkg::CORDIC_GAIN;
			y_c[0]   <= '0;
			neg_c[0] <= neg_s4;
		end
	end

	for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_cordic
		logic signed [33:0] xs, ys;
		logic signed [32:0] at;
		assign xs = x_c[k] >>> k;
		assign ys = y_c[k] >>> k;
		assign at = $signed({3'b0, aarm_pkg::ATAN_Q30[k]});

		always_ff @(posedge clk) begin
			if (en) begin
				neg_c[k+1] <= neg_c[k];
				if (!z_c[k][32]) begin
					x_c[k+1] <= x_c[k] - ys;
					y_c[k+1] <= y_c[k] + xs;
					z_c[k+1] <= z_c[k] - at;
				end else begin
					x_c[k+1] <= x_c[k] + ys;
					y_c[k+1] <= y_c[k] - xs;
					z_c[k+1] <= z_c[k] + at;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			c_pd[0] <= neg_c[CORDIC_STEPS] ? -x_c[CORDIC_STEPS] : x_c[CORDIC_STEPS];
			s_pd[0] <= neg_c[CORDIC_STEPS] ? -y_c[CORDIC_STEPS] : y_c[CORDIC_STEPS];
		end
	end

	// delay line to line up with the axis path
	for (genvar k = 0; k < PAD; k++) begin : g_pad
		always_ff @(posedge clk) begin
			if (en) begin
				c_pd[k+1] <= c_pd[k];
				s_pd[k+1] <= s_pd[k];
			end
		end
	end

	assign c = c_pd[PAD];
	assign s = s_pd[PAD];

endmodule

// File: rtl/arbitrary_axis_rotation_matrix_core.sv
// an accepted request passes the 76-stage pipeline and loads the serializer as row 0;
// rows 1 and 2 follow in the next cycles when out_ready is high
// the three-row output serializer holds each result until its last row is taken;
// the pipeline accepts while its last stage is empty or the serializer can load
// reset: valid bits and the output serializer clear, data registers are not reset
module arbitrary_axis_rotation_matrix_core #(
	parameter int FRAC_BITS    = aarm_pkg::FRAC_BITS_DEF,
	parameter int CORDIC_STEPS = aarm_pkg::CORDIC_STEPS_DEF,
	localparam int ANGLE_W     = FRAC_BITS + 10
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic signed [31:0]        point_a_x,
	input  logic signed [31:0]        point_a_y,
	input  logic signed [31:0]        point_a_z,
	input  logic signed [31:0]        point_b_x,
	input  logic signed [31:0]        point_b_y,
	input  logic signed [31:0]        point_b_z,
	input  logic signed [ANGLE_W-1:0] angle_degrees,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [1:0]                row_index,
	output logic signed [47:0]        entry_col0,
	output logic signed [47:0]        entry_col1,
	output logic signed [47:0]        entry_col2,
	output logic signed [47:0]        entry_translation,
	output logic                      degenerate_axis,
	output logic                      last_row
);

	localparam int SH_OUT = aarm_pkg::Q - FRAC_BITS;

	logic                en, load;
	logic signed [31:0]  pa [3], pb [3];
	logic                ax_valid, ax_degen;
	logic signed [31:0]  ax_n [3], ax_a [3];
	logic signed [33:0]  cs_c, cs_s;

	logic                v_s1, v_s2, v_s3, v_s4, v_s5;
	logic signed [63:0]  nn_s1 [6];
	logic signed [65:0]  sn_s1 [3];
	logic signed [34:0]  omc_s1, omc_s2;
	logic signed [33:0]  c_s1, c_s2, c_s3;
	logic signed [31:0]  a_s1 [3], a_s2 [3], a_s3 [3], a_s4 [3], a_s5 [3];
	logic                dg_s1, dg_s2, dg_s3, dg_s4, dg_s5;
	logic signed [33:0]  nn_s2 [6];
	logic signed [33:0]  sn_s2 [3], sn_s3 [3];
	logic signed [68:0]  tm_s3 [6];
	logic signed [34:0]  r_s4 [3][3], r_s5 [3][3];
	logic signed [66:0]  pr_s5 [3][3];

	logic signed [47:0]  ent_d [3][3];
	logic signed [47:0]  trn_d [3];
	logic signed [47:0]  ent_q [3][3];
	logic signed [47:0]  trn_q [3];
	logic                dg_q, busy_q;
	logic [1:0]          row_q;

	assign pa[0] = point_a_x;
	assign pa[1] = point_a_y;
	assign pa[2] = point_a_z;
	assign pb[0] = point_b_x;
	assign pb[1] = point_b_y;
	assign pb[2] = point_b_z;

	// the whole pipeline moves unless a finished request waits on the serializer
	assign load     = v_s5 && (!busy_q || (out_ready && row_q == aarm_pkg::ROW_LAST));
	assign en       = !v_s5 || load;
	assign in_ready = en;

	aarm_axis u_axis (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (in_valid),
		.pa       (pa),
		.pb       (pb),
		.valid    (ax_valid),
		.n        (ax_n),
		.a        (ax_a),
		.degen    (ax_degen)
	);

	aarm_angle #(
		.FRAC_BITS    (FRAC_BITS),
		.CORDIC_STEPS (CORDIC_STEPS)
	) u_angle (
		.clk   (clk),
		.en    (en),
		.angle (angle_degrees),
		.c     (cs_c),
		.s     (cs_s)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s1 <= ax_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// ni*nj pairs: 00 11 22 01 02 12
			nn_s1[0] <= 64'(ax_n[0]) * 64'(ax_n[0]);
			nn_s1[1] <= 64'(ax_n[1]) * 64'(ax_n[1]);
			nn_s1[2] <= 64'(ax_n[2]) * 64'(ax_n[2]);
			nn_s1[3] <= 64'(ax_n[0]) * 64'(ax_n[1]);
			nn_s1[4] <= 64'(ax_n[0]) * 64'(ax_n[2]);
			nn_s1[5] <= 64'(ax_n[1]) * 64'(ax_n[2]);
			for (int k = 0; k < 3; k++)
				sn_s1[k] <= 66'(cs_s) * 66'(ax_n[k]);
			omc_s1 <= 35'(aarm_pkg::ONE_Q30) - 35'(cs_c);
			c_s1   <= cs_c;
			a_s1   <= ax_a;
			dg_s1  <= ax_degen;

			for (int p = 0; p < 6; p++)
				nn_s2[p] <= 34'(aarm_pkg::rnd_shift(72'(nn_s1[p]), aarm_pkg::Q));
			for (int k = 0; k < 3; k++)
				sn_s2[k] <= 34'(aarm_pkg::rnd_shift(72'(sn_s1[k]), aarm_pkg::Q));
			omc_s2 <= omc_s1;
			c_s2   <= c_s1;
			a_s2   <= a_s1;
			dg_s2  <= dg_s1;

			for (int p = 0; p < 6; p++)
				tm_s3[p] <= 69'(omc_s2) * 69'(nn_s2[p]);
			sn_s3 <= sn_s2;
			c_s3  <= c_s2;
			a_s3  <= a_s2;
			dg_s3 <= dg_s2;

			a_s4  <= a_s3;
			dg_s4 <= dg_s3;

			for (int i = 0; i < 3; i++)
				for (int j = 0; j < 3; j++)
					pr_s5[i][j] <= 67'(r_s4[i][j]) * 67'(a_s4[j]);
			r_s5  <= r_s4;
			a_s5  <= a_s4;
			dg_s5 <= dg_s4;
		end
	end

	// rotation entries, identity for a zero-length axis
	always_ff @(posedge clk) begin
		logic signed [33:0] t [6];
		if (en) begin
			for (int p = 0; p < 6; p++)
				t[p] = 34'(aarm_pkg::rnd_shift(72'(tm_s3[p]), aarm_pkg::Q));
			if (dg_s3) begin
				for (int i = 0; i < 3; i++)
					for (int j = 0; j < 3; j++)
						r_s4[i][j] <= (i == j) ? 35'(aarm_pkg::ONE_Q30) : '0;
			end else begin
				r_s4[0][0] <= 35'(c_s3) + 35'(t[0]);
				r_s4[1][1] <= 35'(c_s3) + 35'(t[1]);
				r_s4[2][2] <= 35'(c_s3) + 35'(t[2]);
				r_s4[0][1] <= 35'(t[3]) - 35'(sn_s3[2]);
				r_s4[1][0] <= 35'(t[3]) + 35'(sn_s3[2]);
				r_s4[0][2] <= 35'(t[4]) + 35'(sn_s3[1]);
				r_s4[2][0] <= 35'(t[4]) - 35'(sn_s3[1]);
				r_s4[1][2] <= 35'(t[5]) - 35'(sn_s3[0]);
				r_s4[2][1] <= 35'(t[5]) + 35'(sn_s3[0]);
			end
		end
	end

	// translation A - R*A; the sum stays within 42 bits so 48-bit saturation never bites
	always_comb begin
		logic signed [41:0] acc;
		for (int i = 0; i < 3; i++) begin
			acc = 42'(a_s5[i]);
			for (int j = 0; j < 3; j++) begin
				acc = acc - 42'(aarm_pkg::rnd_shift(72'(pr_s5[i][j]), aarm_pkg::Q));
				ent_d[i][j] = 48'(aarm_pkg::rnd_shift(72'(r_s5[i][j]), SH_OUT));
			end
			trn_d[i] = dg_s5 ? '0 : 48'(acc);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			row_q  <= aarm_pkg::ROW_FIRST;
		end else if (load) begin
			busy_q <= 1'b1;
			row_q  <= aarm_pkg::ROW_FIRST;
		end else if (busy_q && out_ready) begin
			if (row_q == aarm_pkg::ROW_LAST)
				busy_q <= 1'b0;
			else
				row_q <= row_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			ent_q <= ent_d;
			trn_q <= trn_d;
			dg_q  <= dg_s5;
		end
	end

	always_comb begin
		case (row_q)
			aarm_pkg::ROW_FIRST: begin
				entry_col0        = ent_q[0][0];
				entry_col1        = ent_q[0][1];
				entry_col2        = ent_q[0][2];
				entry_translation = trn_q[0];
			end
			aarm_pkg::ROW_MID: begin
				entry_col0        = ent_q[1][0];
				entry_col1        = ent_q[1][1];
				entry_col2        = ent_q[1][2];
				entry_translation = trn_q[1];
			end
			default: begin
				entry_col0        = ent_q[2][0];
				entry_col1        = ent_q[2][1];
				entry_col2        = ent_q[2][2];
				entry_translation = trn_q[2];
			end
		endcase
	end

	assign out_valid       = busy_q;
	assign row_index       = row_q;
	assign degenerate_axis = dg_q;
	assign last_row        = (row_q == aarm_pkg::ROW_LAST);

endmodule

// File: rtl/aarm_checker.sv
`include "arbitrary_axis_rotation_matrix_core_macros.svh"

module aarm_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               out_valid,
	input logic               out_ready,
	input logic [1:0]         row_index,
	input logic signed [47:0] entry_col0,
	input logic               degenerate_axis,
	input logic               last_row
);

	`AARM_ASSERT_IMPL(a_last_mark, clk, arst_n, out_valid, last_row == (row_index == aarm_pkg::ROW_LAST), "last_row mark does not match row 2")
	`AARM_ASSERT_NEXT(a_rows_burst, clk, arst_n, out_valid && out_ready && !last_row, out_valid && $stable(degenerate_axis), "rows of one request broke apart")
	`AARM_ASSERT_NEXT(a_row_step, clk, arst_n, out_valid && out_ready && row_index == aarm_pkg::ROW_FIRST, row_index == aarm_pkg::ROW_MID, "row 1 did not follow row 0")
	`AARM_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(row_index) && $stable(entry_col0), "stalled result changed")

endmodule

bind arbitrary_axis_rotation_matrix_core aarm_checker u_aarm_checker (.*);

// File: tb/sv/arbitrary_axis_rotation_matrix_checker.sv
`timescale 1ns / 1ps

module arbitrary_axis_rotation_matrix_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_ready,
	input  logic signed [31:0] point_a_x,
	input  logic signed [31:0] point_a_y,
	input  logic signed [31:0] point_a_z,
	input  logic signed [31:0] point_b_x,
	input  logic signed [31:0] point_b_y,
	input  logic signed [31:0] point_b_z,
	input  logic signed [25:0] angle_degrees,
	input  logic               out_valid,
	input  logic               out_ready,
	input  logic [1:0]         row_index,
	input  logic signed [47:0] entry_col0,
	input  logic signed [47:0] entry_col1,
	input  logic signed [47:0] entry_col2,
	input  logic signed [47:0] entry_translation,
	input  logic               degenerate_axis,
	input  logic               last_row,
	output int                 errors,
	output int                 rows_pending,
	output int                 rows_seen,
	output int                 degen_seen
);

	typedef struct {
		logic [1:0]  row;
		logic [47:0] col [3];
		logic [47:0] trans;
		logic        degen;
		logic        last;
	} matrix_row_t;

	matrix_row_t row_queue[$];

	function automatic longint round_away(input longint v, input int sh);
		longint unsigned m;
		if (sh == 0)
			return v;
		m = (v < 0) ? longint'(-v) : v;
		m = (m + (64'd1 << (sh - 1))) >> sh;
		return (v < 0) ? -longint'(m) : longint'(m);
	endfunction

	function automatic longint mul_q30(input longint a, input longint b);
		return round_away(a * b, 30);
	endfunction

	function automatic longint unsigned int_sqrt(input longint unsigned x);
		longint unsigned rem, root, b;
		rem = x;
		root = 0;
		b = 64'd1 << 62;
		while (b > x)
			b >>= 2;
		while (b != 0) begin
			if (rem >= root + b) begin
				rem -= root + b;
				root = (root >> 1) + b;
			end else begin
				root >>= 1;
			end
			b >>= 2;
		end
		return root;
	endfunction

	task automatic predict_rows(input longint pa [3], input longint pb [3],
			input longint ang);
		longint d [3], n [3], rot [3][3];
		longint unsigned mag [3], mx, len, q;
		longint t, z, x, y, xs, ys, c, s, omc, tr, sat;
		logic neg, degen;
		matrix_row_t r;
		neg = 0;
		for (int i = 0; i < 3; i++)
			d[i] = pb[i] - pa[i];
		degen = (d[0] == 0 && d[1] == 0 && d[2] == 0);
		if (degen) begin
			for (int i = 0; i < 3; i++)
				for (int j = 0; j < 3; j++)
					rot[i][j] = (i == j) ? (64'sd1 << 30) : 0;
		end else begin
			for (int i = 0; i < 3; i++)
				mag[i] = (d[i] < 0) ? longint'(-d[i]) : d[i];
			mx = mag[0];
			if (mag[1] > mx) mx = mag[1];
			if (mag[2] > mx) mx = mag[2];
			while (mx >= (64'd1 << 30)) begin
				mx >>= 1;
				for (int i = 0; i < 3; i++) mag[i] >>= 1;
			end
			while (mx < (64'd1 << 29)) begin
				mx <<= 1;
				for (int i = 0; i < 3; i++) mag[i] <<= 1;
			end
			len = int_sqrt(mag[0] * mag[0] + mag[1] * mag[1] + mag[2] * mag[2]);
			for (int i = 0; i < 3; i++) begin
				q = ((mag[i] << 30) + (len >> 1)) / len;
				n[i] = (d[i] < 0) ? -longint'(q) : longint'(q);
			end
			// fold angle into (-180, 180] then into [-90, 90]
			t = ang % (64'sd360 << 16);
			if (t > (64'sd180 << 16)) t -= 64'sd360 << 16;
			else if (t <= -(64'sd180 << 16)) t += 64'sd360 << 16;
			if (t > (64'sd90 << 16)) begin
				t -= 64'sd180 << 16;
				neg = 1;
			end else if (t < -(64'sd90 << 16)) begin
				t += 64'sd180 << 16;
				neg = 1;
			end
			z = round_away(t * longint'(aarm_pkg::DEG2RAD_Q30), 16);
			x = longint'(aarm_pkg::CORDIC_GAIN);
			y = 0;
			for (int k = 0; k < 20; k++) begin
				xs = x >>> k;
				ys = y >>> k;
				if (z >= 0) begin
					x -= ys; y += xs; z -= longint'(aarm_pkg::ATAN_Q30[k]);
				end else begin
					x += ys; y -= xs; z += longint'(aarm_pkg::ATAN_Q30[k]);
				end
			end
			c = neg ? -x : x;
			s = neg ? -y : y;
			omc = (64'sd1 << 30) - c;
			for (int i = 0; i < 3; i++)
				rot[i][i] = c + mul_q30(omc, mul_q30(n[i], n[i]));
			rot[0][1] = mul_q30(omc, mul_q30(n[0], n[1])) - mul_q30(s, n[2]);
			rot[1][0] = mul_q30(omc, mul_q30(n[0], n[1])) + mul_q30(s, n[2]);
			rot[0][2] = mul_q30(omc, mul_q30(n[0], n[2])) + mul_q30(s, n[1]);
			rot[2][0] = mul_q30(omc, mul_q30(n[0], n[2])) - mul_q30(s, n[1]);
			rot[1][2] = mul_q30(omc, mul_q30(n[1], n[2])) - mul_q30(s, n[0]);
			rot[2][1] = mul_q30(omc, mul_q30(n[1], n[2])) + mul_q30(s, n[0]);
		end
		for (int i = 0; i < 3; i++) begin
			tr = 0;
			if (!degen) begin
				tr = pa[i];
				for (int j = 0; j < 3; j++)
					tr -= round_away(rot[i][j] * pa[j], 30);
			end
			sat = tr;
			if (sat > (64'sd1 << 47) - 1) sat = (64'sd1 << 47) - 1;
			if (sat < -(64'sd1 << 47)) sat = -(64'sd1 << 47);
			r.row = i[1:0];
			for (int j = 0; j < 3; j++)
				r.col[j] = 48'(round_away(rot[i][j], 14));
			r.trans = 48'(sat);
			r.degen = degen;
			r.last = (i == 2);
			row_queue = {row_queue, r};
		end
	endtask

	always @(posedge clk) begin
		longint pa [3], pb [3];
		matrix_row_t e;
		logic bad;
		if (arst_n && in_valid && in_ready) begin
			pa = '{longint'(point_a_x), longint'(point_a_y), longint'(point_a_z)};
			pb = '{longint'(point_b_x), longint'(point_b_y), longint'(point_b_z)};
			predict_rows(pa, pb, longint'(angle_degrees));
		end
		if (arst_n && out_valid && out_ready) begin
			rows_seen++;
			if (degenerate_axis) degen_seen++;
			if (row_queue.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected row %0d with no request waiting", row_index);
			end else begin
				e = row_queue.pop_front();
				bad = (e.row !== row_index) || (e.col[0] !== entry_col0)
					|| (e.col[1] !== entry_col1) || (e.col[2] !== entry_col2)
					|| (e.trans !== entry_translation) || (e.degen !== degenerate_axis)
					|| (e.last !== last_row);
				if (bad) begin
					errors++;
					if (errors <= 10) begin
						$display("mismatch exp row=%0d c=%h %h %h t=%h dg=%b l=%b", e.row,
							e.col[0], e.col[1], e.col[2], e.trans, e.degen, e.last);
						$display("         got row=%0d c=%h %h %h t=%h dg=%b l=%b", row_index,
							entry_col0, entry_col1, entry_col2, entry_translation,
							degenerate_axis, last_row);
					end
				end
			end
		end
		rows_pending <= row_queue.size();
	end

endmodule

// File: tb/sv/arbitrary_axis_rotation_matrix_core_test.sv
`timescale 1ns / 1ps

module arbitrary_axis_rotation_matrix_core_test;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	logic signed [31:0] point_a_x, point_a_y, point_a_z;
	logic signed [31:0] point_b_x, point_b_y, point_b_z;
	logic signed [25:0] angle_degrees;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic [1:0]         row_index;
	logic signed [47:0] entry_col0, entry_col1, entry_col2, entry_translation;
	logic               degenerate_axis;
	logic               last_row;

	int errors, rows_pending, rows_seen, degen_seen;
	int tx_idle_pct, rx_idle_pct;
	int requests_sent;
	int hold_request;
	int hold_left;
	bit hold_taken;
	int cycles;

	arbitrary_axis_rotation_matrix_core u_top (.*);

	arbitrary_axis_rotation_matrix_checker u_check (.*);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	initial begin
		arst_n = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
	end

	// receiver side, with a single long hold-off
	always @(posedge clk) begin
		if (hold_request > 0 && !hold_taken) begin
			hold_taken <= 1'b1;
			hold_left <= hold_request;
			out_ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > 300000) begin
			$display("status: fail");
			$finish;
		end
	end

	task automatic send_request(input logic signed [31:0] ax, ay, az, bx, by, bz,
			input int ang);
		if ($urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(4, 1)) @(posedge clk);
		end
		point_a_x <= ax; point_a_y <= ay; point_a_z <= az;
		point_b_x <= bx; point_b_y <= by; point_b_z <= bz;
		angle_degrees <= 26'(ang);
		in_valid <= 1'b1;
		// in_ready is settled between the falling and the next rising edge
		do @(negedge clk); while (!in_ready);
		@(posedge clk);
		requests_sent++;
	endtask

	task automatic drain;
		in_valid <= 1'b0;
		@(posedge clk);
		while (rows_pending != 0 || in_valid) @(posedge clk);
	endtask

	function automatic logic signed [31:0] rand_coord;
		case ($urandom_range(3))
			0: return $urandom;
			1: return $signed($urandom_range(2 * 65536 * 100)) - 65536 * 100;
			2: return $signed($urandom_range(64)) - 32;
			default: return ($urandom_range(1)) ? 32'sh7fffffff : 32'sh80000000;
		endcase
	endfunction

	task automatic random_request;
		logic signed [31:0] ax, ay, az, bx, by, bz;
		int ang;
		ax = rand_coord(); ay = rand_coord(); az = rand_coord();
		bx = rand_coord(); by = rand_coord(); bz = rand_coord();
		case ($urandom_range(9))
			0: begin bx = ax; by = ay; bz = az; end
			1: begin by = ay; bz = az; end
			2: begin bx = ax; bz = az; end
			default: ;
		endcase
		if ($urandom_range(4) == 0)
			ang = ($signed($urandom_range(8)) - 4) * (90 << 16);
		else
			ang = $signed($urandom_range(47185920)) - 23592960;
		send_request(ax, ay, az, bx, by, bz, ang);
	endtask

	localparam int DEG = 65536;

	initial begin
		in_valid = 1'b0;
		{point_a_x, point_a_y, point_a_z} = '0;
		{point_b_x, point_b_y, point_b_z} = '0;
		angle_degrees = '0;
		tx_idle_pct = 19;
		rx_idle_pct = 80;
		hold_request = 0;
		requests_sent = 0;
		@(posedge clk iff arst_n);
		// directed: special angles, coincident points, coordinate extremes
		send_request(0, 0, 0, 65536, 0, 0, 0);
		send_request(0, 0, 0, 0, 65536, 0, 90 * DEG);
		send_request(0, 0, 0, 0, 0, 65536, -90 * DEG);
		send_request(65536, 0, 0, 65536, 65536, 0, 180 * DEG);
		send_request(0, 65536, 0, 0, 0, 0, -180 * DEG);
		send_request(1, 2, 3, 4, 5, 6, 360 * DEG);
		send_request(1, 2, 3, -4, 5, -6, -360 * DEG);
		send_request(7, 7, 7, 7, 7, 7, 45 * DEG);
		send_request(32'sh80000000, 32'sh80000000, 32'sh80000000,
			32'sh80000000, 32'sh80000000, 32'sh80000000, 123 * DEG);
		send_request(32'sh80000000, 32'sh80000000, 32'sh80000000,
			32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 30 * DEG);
		send_request(32'sh7fffffff, 32'sh80000000, 0, 32'sh80000000, 32'sh7fffffff, 1,
			-270 * DEG);
		send_request(0, 0, 0, 1, 1, 1, 1);
		send_request(0, 0, 0, -1, 0, 0, -1);
		send_request(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 0, 0, 65536,
			23592960);
		send_request(32'sh80000000, 32'sh7fffffff, 32'sh80000000, 5, 0, 0,
			-23592960);
		send_request(100, 200, 300, 100, 200, 301, 90 * DEG + 1);
		send_request(100, 200, 300, 101, 200, 300, 270 * DEG);
		send_request(-5, -5, -5, 5, 5, 5, 135 * DEG);
		send_request(0, 0, 0, 3, 4, 0, -45 * DEG);
		send_request(65536, 65536, 65536, 0, 0, 0, 179 * DEG);
		drain();
		// after every row has come back, random requests against a mostly idle receiver
		repeat (100) random_request();
		drain();
		tx_idle_pct = 80;
		rx_idle_pct = 19;
		repeat (100) random_request();
		drain();
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		hold_request = 400;
		repeat (90) random_request();
		drain();
		repeat (100) @(posedge clk);
		$display("covered %0d requests, %0d rows checked, %0d rows on coincident points",
			requests_sent, rows_seen, degen_seen);
		if (errors == 0) begin
			$display("status: pass");
		end else begin
			$display("%0d mismatches", errors);
			$display("status: fail");
		end
		$finish;
	end

endmodule

// File: sim.f
+incdir+rtl
rtl/aarm_pkg.sv
rtl/aarm_axis.sv
rtl/aarm_angle.sv
rtl/arbitrary_axis_rotation_matrix_core.sv
rtl/aarm_checker.sv
tb/sv/arbitrary_axis_rotation_matrix_checker.sv
tb/sv/arbitrary_axis_rotation_matrix_core_test.sv
